>>> rtl/pgalloc_pkg.sv
package pgalloc_pkg;

	localparam int NUM_PAGES_DEF  = 32768;
	localparam int COUNT_BITS_DEF = 8;

	localparam int PAGE_W   = 15;
	localparam int LIMIT_W  = 16;
	localparam int STATUS_W = 3;
	localparam int REFCNT_W = 8;
	localparam int CFG_W    = 16;

	localparam logic [LIMIT_W-1:0] PAGE_LIMIT_RST = 16'd32768;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_ADDREF = 2'd2,
		OP_INIT   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 3'd0,
		STS_OOM   = 3'd1,
		STS_RANGE = 3'd2,
		STS_DFREE = 3'd3,
		STS_SAT   = 3'd4
	} status_t;

	typedef enum logic {
		REG_FIRST_PAGE = 1'b0,
		REG_PAGE_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		op_t               operation;
		logic [PAGE_W-1:0] page;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0]   alloc_page;
		status_t             status;
		logic [REFCNT_W-1:0] ref_count;
		logic                released;
	} rsp_t;

	typedef struct packed {
		reg_idx_t         index;
		logic [CFG_W-1:0] value;
	} cfg_t;

	typedef enum logic [1:0] {
		S_CLEAR = 2'd0,
		S_IDLE  = 2'd1,
		S_EXEC  = 2'd2
	} state_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic clr_run;
	} cmd_t;

	typedef struct packed {
		logic req_init;
		logic clr_last;
		logic clr_init;
		logic slot_free;
	} sts_t;

endpackage

>>> rtl/pgalloc_req_if.sv
interface pgalloc_req_if;
	logic                valid;
	logic                ready;
	pgalloc_pkg::req_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pgalloc_rsp_if.sv
interface pgalloc_rsp_if;
	logic                valid;
	logic                ready;
	pgalloc_pkg::rsp_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/pgalloc_cfg_if.sv
interface pgalloc_cfg_if;
	logic                valid;
	logic                ready;
	pgalloc_pkg::cfg_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/page_allocator_with_refcounts.sv
// Page allocator with a reference count for every page.
// Requests arrive on req (operation and page) and each one gives exactly one
// word on rsp (allocated page, status, count after the operation, released).
// Registers first_page and page_limit are written on cfg, which is always
// ready and should only be written while no request is in flight.
// Allocate, free and add-reference each first accept the word and read the
// count and stack memories, then update them and load the response register
// once it is free. No new request is taken until the last one has done so.
// Initialize zeroes the count memory one entry per cycle, and gives its
// response once the whole memory is clear and the free stack is reset.
// After reset the same clearing pass runs and req stays not ready until
// it ends; nothing can be allocated until an initialize.
// When the receiver stalls, the response waits in its register and one more
// request is still accepted; that request then waits for the register to
// drain before it completes, and req stays not ready meanwhile.
module page_allocator_with_refcounts #(
	parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
	parameter int COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	pgalloc_req_if.sink   req,
	pgalloc_rsp_if.source rsp,
	pgalloc_cfg_if.sink   cfg
);

	pgalloc_pkg::cmd_t cmd;
	pgalloc_pkg::sts_t sts;
	logic              ready;

	assign req.ready = ready;

	pgalloc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pgalloc_dp #(
		.NUM_PAGES  (NUM_PAGES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.rsp      (rsp),
		.cfg      (cfg),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

>>> rtl/pgalloc_ram.sv
module pgalloc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/pgalloc_ctrl.sv
module pgalloc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  pgalloc_pkg::sts_t   sts,
	output pgalloc_pkg::cmd_t   cmd
);

	pgalloc_pkg::state_t state_q;
	pgalloc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pgalloc_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pgalloc_pkg::S_CLEAR: begin
				if (sts.clr_last) begin
					state_d = sts.clr_init ? pgalloc_pkg::S_EXEC : pgalloc_pkg::S_IDLE;
				end
			end
			pgalloc_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = sts.req_init ? pgalloc_pkg::S_CLEAR : pgalloc_pkg::S_EXEC;
				end
			end
			pgalloc_pkg::S_EXEC: begin
				if (sts.slot_free) begin
					state_d = pgalloc_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pgalloc_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		cmd.accept  = 1'b0;
		cmd.exec    = 1'b0;
		cmd.clr_run = 1'b0;
		case (state_q)
			pgalloc_pkg::S_CLEAR: begin
				cmd.clr_run = 1'b1;
			end
			pgalloc_pkg::S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			pgalloc_pkg::S_EXEC: begin
				cmd.exec = sts.slot_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/pgalloc_dp.sv
module pgalloc_dp #(
	parameter int NUM_PAGES  = pgalloc_pkg::NUM_PAGES_DEF,
	parameter int COUNT_BITS = pgalloc_pkg::COUNT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pgalloc_pkg::req_t   req_data,
	pgalloc_rsp_if.source       rsp,
	pgalloc_cfg_if.sink         cfg,
	input  pgalloc_pkg::cmd_t   cmd,
	output pgalloc_pkg::sts_t   sts
);

	localparam int AW  = $clog2(NUM_PAGES);
	localparam int WW  = (AW > pgalloc_pkg::LIMIT_W) ? AW : pgalloc_pkg::LIMIT_W;
	localparam int LW  = (AW + 1 > pgalloc_pkg::LIMIT_W + 1) ? AW + 1 : pgalloc_pkg::LIMIT_W + 1;
	localparam int CW8 = (COUNT_BITS > pgalloc_pkg::REFCNT_W) ? COUNT_BITS : pgalloc_pkg::REFCNT_W;
	localparam int DW  = AW + 1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
	localparam logic [AW-1:0]         ADDR_LAST = AW'(NUM_PAGES - 1);
	localparam logic [DW-1:0]         DEPTH_FULL = DW'(NUM_PAGES);
	localparam logic [LW-1:0]         LIMIT_CAP = LW'(NUM_PAGES);

	logic [pgalloc_pkg::PAGE_W-1:0]  first_page_q;
	logic [pgalloc_pkg::LIMIT_W-1:0] page_limit_q;
	pgalloc_pkg::op_t                op_q;
	logic [pgalloc_pkg::PAGE_W-1:0]  page_q;
	logic [DW-1:0]                   depth_q;
	logic [pgalloc_pkg::LIMIT_W-1:0] frontier_q;
	logic [AW-1:0]                   clr_addr_q;
	logic                            clr_init_q;
	logic                            rsp_valid_q;
	pgalloc_pkg::rsp_t               rsp_data_q;

	logic [DW-1:0]                   depth_d;
	logic [pgalloc_pkg::LIMIT_W-1:0] frontier_d;
	pgalloc_pkg::rsp_t               rsp_d;

	logic [WW-1:0]                   req_page_w;
	logic [WW-1:0]                   page_w;
	logic [WW-1:0]                   front_w;
	logic [WW-1:0]                   got_w;
	logic [DW-1:0]                   depth_m1;
	logic [pgalloc_pkg::LIMIT_W-1:0] frontier_m1;
	logic [LW-1:0]                   lim_w;
	logic [pgalloc_pkg::LIMIT_W-1:0] eff_lim;
	logic                            in_range;
	logic [AW-1:0]                   got;
	logic [CW8-1:0]                  cnt_w;

	logic                            cnt_we;
	logic [AW-1:0]                   cnt_waddr;
	logic [COUNT_BITS-1:0]           cnt_wdata;
	logic                            ex_cnt_we;
	logic [COUNT_BITS-1:0]           ex_cnt_wdata;
	logic [AW-1:0]                   ex_cnt_waddr;
	logic [COUNT_BITS-1:0]           cnt_rdata;
	logic [COUNT_BITS-1:0]           cnt_new;

	logic                            stk_we;
	logic [AW-1:0]                   stk_rdata;

	assign req_page_w  = WW'(req_data.page);
	assign page_w      = WW'(page_q);
	assign depth_m1    = depth_q - DW'(1);
	assign frontier_m1 = frontier_q - pgalloc_pkg::LIMIT_W'(1);
	assign front_w     = WW'(frontier_m1);

	assign lim_w   = (LW'(page_limit_q) > LIMIT_CAP) ? LIMIT_CAP : LW'(page_limit_q);
	assign eff_lim = lim_w[pgalloc_pkg::LIMIT_W-1:0];
	assign in_range = (page_q >= first_page_q)
		&& (pgalloc_pkg::LIMIT_W'(page_q) < eff_lim);

	assign got   = (depth_q != '0) ? stk_rdata : front_w[AW-1:0];
	assign got_w = WW'(got);

	pgalloc_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_PAGES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cmd.accept),
		.raddr (req_page_w[AW-1:0]),
		.rdata (cnt_rdata)
	);

	pgalloc_ram #(
		.WIDTH (AW),
		.DEPTH (NUM_PAGES)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[AW-1:0]),
		.wdata (page_w[AW-1:0]),
		.re    (cmd.accept),
		.raddr (depth_m1[AW-1:0]),
		.rdata (stk_rdata)
	);

	always_comb begin
		depth_d         = depth_q;
		frontier_d      = frontier_q;
		ex_cnt_we       = 1'b0;
		ex_cnt_waddr    = page_w[AW-1:0];
		ex_cnt_wdata    = COUNT_ONE;
		stk_we          = 1'b0;
		cnt_new         = cnt_rdata;
		rsp_d.alloc_page = '0;
		rsp_d.status     = pgalloc_pkg::STS_OK;
		rsp_d.ref_count  = '0;
		rsp_d.released   = 1'b0;
		case (op_q)
			pgalloc_pkg::OP_INIT: begin
				depth_d    = '0;
				frontier_d = eff_lim;
			end
			pgalloc_pkg::OP_ALLOC: begin
				if (depth_q != '0) begin
					depth_d = depth_m1;
				end else if (frontier_q > pgalloc_pkg::LIMIT_W'(first_page_q)) begin
					frontier_d = frontier_m1;
				end else begin
					rsp_d.status = pgalloc_pkg::STS_OOM;
					cnt_new      = '0;
				end
				if (rsp_d.status == pgalloc_pkg::STS_OK) begin
					ex_cnt_we        = 1'b1;
					ex_cnt_waddr     = got;
					ex_cnt_wdata     = COUNT_ONE;
					rsp_d.alloc_page = got_w[pgalloc_pkg::PAGE_W-1:0];
					cnt_new          = COUNT_ONE;
				end
			end
			pgalloc_pkg::OP_FREE: begin
				if (!in_range) begin
					rsp_d.status = pgalloc_pkg::STS_RANGE;
					cnt_new      = '0;
				end else if (cnt_rdata == '0) begin
					rsp_d.status = pgalloc_pkg::STS_DFREE;
				end else begin
					cnt_new      = cnt_rdata - COUNT_ONE;
					ex_cnt_we    = 1'b1;
					ex_cnt_wdata = cnt_new;
					if (cnt_new == '0) begin
						rsp_d.released = 1'b1;
						if (depth_q != DEPTH_FULL) begin
							stk_we  = cmd.exec;
							depth_d = depth_q + DW'(1);
						end
					end
				end
			end
			pgalloc_pkg::OP_ADDREF: begin
				if (!in_range) begin
					rsp_d.status = pgalloc_pkg::STS_RANGE;
					cnt_new      = '0;
				end else if (cnt_rdata == COUNT_MAX) begin
					rsp_d.status = pgalloc_pkg::STS_SAT;
				end else begin
					cnt_new      = cnt_rdata + COUNT_ONE;
					ex_cnt_we    = 1'b1;
					ex_cnt_wdata = cnt_new;
				end
			end
			default: begin
				rsp_d.status = pgalloc_pkg::STS_OK;
			end
		endcase
		if (op_q == pgalloc_pkg::OP_INIT) begin
			cnt_new = '0;
		end
		cnt_w           = CW8'(cnt_new);
		rsp_d.ref_count = cnt_w[pgalloc_pkg::REFCNT_W-1:0];
	end

	assign cnt_we    = cmd.clr_run || (cmd.exec && ex_cnt_we);
	assign cnt_waddr = cmd.clr_run ? clr_addr_q : ex_cnt_waddr;
	assign cnt_wdata = cmd.clr_run ? '0 : ex_cnt_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= '0;
			page_limit_q <= pgalloc_pkg::PAGE_LIMIT_RST;
			depth_q      <= '0;
			frontier_q   <= '0;
			clr_addr_q   <= '0;
			clr_init_q   <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.data.index)
					pgalloc_pkg::REG_FIRST_PAGE: begin
						first_page_q <= cfg.data.value[pgalloc_pkg::PAGE_W-1:0];
					end
					pgalloc_pkg::REG_PAGE_LIMIT: begin
						page_limit_q <= cfg.data.value;
					end
					default: begin
						page_limit_q <= page_limit_q;
					end
				endcase
			end
			if (cmd.accept && sts.req_init) begin
				clr_init_q <= 1'b1;
				clr_addr_q <= '0;
			end
			if (cmd.clr_run) begin
				clr_addr_q <= sts.clr_last ? '0 : clr_addr_q + AW'(1);
				if (sts.clr_last) begin
					clr_init_q <= 1'b0;
				end
			end
			if (cmd.exec) begin
				depth_q     <= depth_d;
				frontier_q  <= frontier_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= req_data.operation;
			page_q <= req_data.page;
		end
		if (cmd.exec) begin
			rsp_data_q <= rsp_d;
		end
	end

	assign cfg.ready = 1'b1;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	assign sts.req_init  = (req_data.operation == pgalloc_pkg::OP_INIT);
	assign sts.clr_last  = (clr_addr_q == ADDR_LAST);
	assign sts.clr_init  = clr_init_q;
	assign sts.slot_free = !rsp_valid_q || rsp.ready;

endmodule
